FILE: hdl/vdcl_pkg.sv
// ----------------------------------------------------------------------------
// vdcl_pkg
// Shared widths, opcodes and status codes of the current limiter table.
// ----------------------------------------------------------------------------
package vdcl_pkg;

  localparam int DATA_W         = 24;
  localparam int OPC_W          = 2;
  localparam int STAT_W         = 2;
  localparam int PTS_W          = 4;
  localparam int MAX_POINTS_DEF = 8;

  // difference of two 24-bit values, product and quotient widths
  localparam int DIFF_W  = DATA_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int QUO_W   = DIFF_W;
  localparam int DCNT_W  = $clog2(QUO_W + 1);

  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNLIMITED = 2'd3;

  localparam logic signed [DATA_W-1:0] UNLIMITED_CODE = 24'sh7FFFFF;

endpackage

FILE: hdl/vdcl_in_if.sv
// ----------------------------------------------------------------------------
// vdcl_in_if
// Command channel of the current limiter: opcode, voltage and current.
// ----------------------------------------------------------------------------
interface vdcl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [vdcl_pkg::OPC_W-1:0]           opcode;
  logic signed [vdcl_pkg::DATA_W-1:0]   voltage_value;
  logic signed [vdcl_pkg::DATA_W-1:0]   current_value;

  modport source (output valid, opcode, voltage_value, current_value, input ready);
  modport sink   (input valid, opcode, voltage_value, current_value, output ready);
endinterface

FILE: hdl/vdcl_out_if.sv
// ----------------------------------------------------------------------------
// vdcl_out_if
// Result channel of the current limiter: status, limit and table fill.
// ----------------------------------------------------------------------------
interface vdcl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [vdcl_pkg::STAT_W-1:0]          status;
  logic signed [vdcl_pkg::DATA_W-1:0]   current_limit;
  logic [vdcl_pkg::PTS_W-1:0]           points_held;

  modport source (output valid, status, current_limit, points_held, input ready);
  modport sink   (input valid, status, current_limit, points_held, output ready);
endinterface

FILE: hdl/voltage_dependent_current_limiter.sv
// ----------------------------------------------------------------------------
// voltage_dependent_current_limiter
// Piecewise-linear current limit table over DC voltage, one sequential divider.
//
// Usage: commands arrive on in_ch (valid/ready), one result per command
// leaves on out_ch. Opcodes: clear, insert breakpoint, query limit.
// in_ch.ready is high only while the sequencer is idle; one command is
// processed at a time. Steps per transaction:
//   clear, unused opcode, query of an empty table: no table access
//   insert: a scan that stops at the insert position, then the shift,
//   a read and a write per moved entry, over the rest of the table
//   query: a scan to the bracketing points; at or beyond an end point
//   that point's current, between points a multiply and a restoring division
// The search pace is set by the single registered read port of the table,
// the division by the restoring subtract unit, one quotient bit per cycle.
// A finished result waits in the out_ch register; the next command is taken
// meanwhile and its result is held back until out_ch.ready frees it.
// Reset (rst_n, synchronous) empties the table and drops any pending result;
// table entries are not cleared and are only read below the point count.
// ----------------------------------------------------------------------------
module voltage_dependent_current_limiter #(
  parameter int MAX_POINTS = vdcl_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vdcl_in_if.sink     in_ch,
  vdcl_out_if.source  out_ch
);
  import vdcl_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_INS_CHK, S_SH_RD, S_SH_WR, S_INS_WR,
    S_MUL, S_DIV_LD, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              pos_r, pos_nxt;
  logic [OPC_W-1:0]           opc_r, opc_nxt;
  logic signed [DATA_W-1:0]   v_r, v_nxt;
  logic signed [DATA_W-1:0]   c_r, c_nxt;
  logic signed [DATA_W-1:0]   prev_v_r, prev_v_nxt;
  logic signed [DATA_W-1:0]   prev_i_r, prev_i_nxt;
  logic signed [DIFF_W-1:0]   di_r, di_nxt;
  logic [DIFF_W-1:0]          dv_r, dv_nxt;
  logic [DIFF_W-1:0]          span_r, span_nxt;
  logic                       neg_r, neg_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic [DIFF_W-1:0]          rem_r, rem_nxt;
  logic [QUO_W-1:0]           quo_r, quo_nxt;
  logic [DCNT_W-1:0]          dcnt_r, dcnt_nxt;
  logic [STAT_W-1:0]          res_st_r, res_st_nxt;
  logic signed [DATA_W-1:0]   res_lim_r, res_lim_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]          out_st_r, out_st_nxt;
  logic signed [DATA_W-1:0]   out_lim_r, out_lim_nxt;
  logic [PTS_W-1:0]           out_pts_r, out_pts_nxt;

  // table storage, one write and one registered read port
  logic signed [DATA_W-1:0]   mem_v [MAX_POINTS];
  logic signed [DATA_W-1:0]   mem_c [MAX_POINTS];
  logic signed [DATA_W-1:0]   rd_v_r, rd_c_r;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic signed [DATA_W-1:0]   wr_v, wr_c;

  logic                       in_acc;
  logic [CW-1:0]              idx_dec;
  logic [DIFF_W-1:0]          di_mag;
  logic [DIFF_W:0]            trial;
  logic                       qbit;
  logic signed [QUO_W:0]      q_signed;
  logic signed [QUO_W+1:0]    lim_sum;
  logic [31:0]                cnt_ext;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign idx_dec  = idx_r - CW'(1);
  assign rd_addr  = (state_r == S_SH_RD) ? idx_dec[AW-1:0] : idx_r[AW-1:0];
  assign di_mag   = di_r[DIFF_W-1] ? DIFF_W'(-di_r) : DIFF_W'(di_r);
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign qbit     = (trial >= {1'b0, span_r});
  assign q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign lim_sum  = (QUO_W+2)'(prev_i_r) + (QUO_W+2)'(q_signed);
  assign cnt_ext  = 32'(cnt_r);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.current_limit = out_lim_r;
  assign out_ch.points_held   = out_pts_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    opc_nxt       = opc_r;
    v_nxt         = v_r;
    c_nxt         = c_r;
    prev_v_nxt    = prev_v_r;
    prev_i_nxt    = prev_i_r;
    di_nxt        = di_r;
    dv_nxt        = dv_r;
    span_nxt      = span_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    res_st_nxt    = res_st_r;
    res_lim_nxt   = res_lim_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_lim_nxt   = out_lim_r;
    out_pts_nxt   = out_pts_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_v          = rd_v_r;
    wr_c          = rd_c_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          opc_nxt     = in_ch.opcode;
          v_nxt       = in_ch.voltage_value;
          c_nxt       = in_ch.current_value;
          idx_nxt     = '0;
          res_st_nxt  = ST_OK;
          res_lim_nxt = '0;
          state_nxt   = S_DONE;
          priority if (in_ch.opcode == OP_CLEAR) begin
            cnt_nxt = '0;
          end else if (in_ch.opcode == OP_INSERT) begin
            state_nxt = S_SCAN_RD;
          end else if (in_ch.opcode == OP_QUERY) begin
            if (cnt_r == '0) begin
              res_st_nxt  = ST_UNLIMITED;
              res_lim_nxt = UNLIMITED_CODE;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end else begin
            // unused opcode: table untouched
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          // ran off the end: above every stored voltage
          if (opc_r == OP_INSERT) begin
            pos_nxt   = cnt_r;
            state_nxt = S_INS_CHK;
          end else begin
            res_lim_nxt = prev_i_r;
            state_nxt   = S_DONE;
          end
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (rd_v_r >= v_r) begin
          if (opc_r == OP_INSERT) begin
            if (rd_v_r == v_r) begin
              res_st_nxt = ST_DUPLICATE;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = idx_r;
              state_nxt = S_INS_CHK;
            end
          end else if (idx_r == '0) begin
            res_lim_nxt = rd_c_r;
            state_nxt   = S_DONE;
          end else begin
            di_nxt    = DIFF_W'(rd_c_r) - DIFF_W'(prev_i_r);
            dv_nxt    = DIFF_W'(DIFF_W'(v_r) - DIFF_W'(prev_v_r));
            span_nxt  = DIFF_W'(DIFF_W'(rd_v_r) - DIFF_W'(prev_v_r));
            state_nxt = S_MUL;
          end
        end else begin
          prev_v_nxt = rd_v_r;
          prev_i_nxt = rd_c_r;
          idx_nxt    = idx_r + CW'(1);
          state_nxt  = S_SCAN_RD;
        end
      end
      S_INS_CHK: begin
        if (cnt_r >= CW'(MAX_POINTS)) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        state_nxt = (idx_r > pos_r) ? S_SH_WR : S_INS_WR;
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_SH_RD;
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        wr_v      = v_r;
        wr_c      = c_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_MUL: begin
        neg_nxt   = di_r[DIFF_W-1];
        prod_nxt  = PROD_W'(di_mag) * PROD_W'(dv_r);
        state_nxt = S_DIV_LD;
      end
      S_DIV_LD: begin
        rem_nxt   = prod_r[PROD_W-1:QUO_W];
        quo_nxt   = prod_r[QUO_W-1:0];
        dcnt_nxt  = DCNT_W'(QUO_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = qbit ? DIFF_W'(trial - {1'b0, span_r}) : trial[DIFF_W-1:0];
        quo_nxt  = {quo_r[QUO_W-2:0], qbit};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_lim_nxt = lim_sum[DATA_W-1:0];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_lim_nxt   = res_lim_r;
          out_pts_nxt   = cnt_ext[PTS_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_st_r  <= out_st_nxt;
    out_lim_r <= out_lim_nxt;
    out_pts_r <= out_pts_nxt;
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    opc_r     <= opc_nxt;
    v_r       <= v_nxt;
    c_r       <= c_nxt;
    prev_v_r  <= prev_v_nxt;
    prev_i_r  <= prev_i_nxt;
    di_r      <= di_nxt;
    dv_r      <= dv_nxt;
    span_r    <= span_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dcnt_r    <= dcnt_nxt;
    res_st_r  <= res_st_nxt;
    res_lim_r <= res_lim_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_v[wr_addr] <= wr_v;
      mem_c[wr_addr] <= wr_c;
    end
    rd_v_r <= mem_v[rd_addr];
    rd_c_r <= mem_c[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.opcode == OP_CLEAR) |=> (cnt_r == '0))
    else $error("clear did not empty the table");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < span_r))
    else $error("division remainder not below span");

  a_unlimited_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_UNLIMITED) |-> (out_lim_r == UNLIMITED_CODE))
    else $error("unlimited status without maximum code");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> ($past(state_r) == S_INS_WR) || ($past(state_r) == S_IDLE))
    else $error("point count changed outside clear or insert");

endmodule
